>>> hw/rtl/assert_macros.svh
// Assertion macros included by fifo_byte_budget_cache.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/fbc_pkg.sv
package fbc_pkg;

	localparam int QUEUE_DEPTH = 32;
	localparam int KEY_BITS    = 32;
	localparam int SIZE_W      = 32;
	localparam int LIM_W       = 6;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = SIZE_W + 1;
	localparam int CFG_IDX_W   = 8;

	typedef logic [KEY_BITS-1:0]    key_t;
	typedef logic [SIZE_W-1:0]      size_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [LIM_W-1:0]       lim_t;
	typedef logic [QUEUE_DEPTH-1:0] qvec_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_EDIT   = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	localparam cfg_idx_t REG_BYTE_BUDGET = cfg_idx_t'(0);
	localparam cfg_idx_t REG_ENTRY_LIMIT = cfg_idx_t'(1);

	localparam size_t BUDGET_RESET = size_t'(1048576);
	localparam lim_t  LIMIT_RESET  = lim_t'(32);

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TOO_LARGE  = 2'd1,
		ST_NOT_FOUND  = 2'd2,
		ST_STILL_OVER = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_EDIT_FIND,
		S_EDIT_CALC,
		S_EDIT_FIT,
		S_REMOVE,
		S_STATUS
	} state_t;

	// Contents of one cell of the queue; tgt marks the entry an edit resizes.
	typedef struct packed {
		key_t  key;
		size_t size;
		logic  tgt;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic load;
		logic upd;
		logic mark;
		logic mark_val;
	} cell_ctl_t;

endpackage

>>> hw/rtl/fbc_ifs.sv
interface fbc_req_if
	import fbc_pkg::*;
();
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	key_t       item_key;
	size_t      item_size;

	modport source(output valid, kind, item_key, item_size, input ready);
	modport sink(input valid, kind, item_key, item_size, output ready);
endinterface

interface fbc_rsp_if
	import fbc_pkg::*;
();
	logic    valid;
	logic    ready;
	logic    is_eviction;
	key_t    evicted_key;
	size_t   evicted_size;
	status_t status;
	logic    last;

	modport source(output valid, is_eviction, evicted_key, evicted_size, status, last,
		input ready);
	modport sink(input valid, is_eviction, evicted_key, evicted_size, status, last,
		output ready);
endinterface

interface fbc_cfg_if
	import fbc_pkg::*;
();
	logic        valid;
	logic        ready;
	cfg_idx_t    index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/fbc_cell.sv
module fbc_cell
	import fbc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    nbr,
	input  key_t      fill_key,
	input  size_t     fill_size,
	input  key_t      cmp_key,
	output entry_t    ent,
	output logic      eq
);

	key_t  key_q;
	size_t size_q;
	logic  tgt_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q  <= nbr.key;
			size_q <= nbr.size;
		end else if (ctl.load) begin
			key_q  <= fill_key;
			size_q <= fill_size;
		end else if (ctl.upd && tgt_q) begin
			size_q <= fill_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= 1'b0;
		end else if (ctl.mark) begin
			tgt_q <= ctl.mark_val;
		end else if (ctl.shift) begin
			tgt_q <= nbr.tgt;
		end else if (ctl.load) begin
			tgt_q <= 1'b0;
		end
	end

	assign ent = '{key: key_q, size: size_q, tgt: tgt_q};
	assign eq  = (key_q == cmp_key);

endmodule

>>> hw/rtl/fifo_byte_budget_cache.sv
// FIFO cache of up to QUEUE_DEPTH (key, size) entries held oldest first in a row of cells;
// removing an entry shifts every younger cell one place toward the head, all in the same cycle.
// An insert that is not too large evicts from the head until the entry limit and the budget
// allow the new entry, then appends it; an edit that is not rejected and finds its key runs
// eviction passes, each of which first recomputes the bytes held by other entries and then
// compares them with the budget. At most one result item leaves per cycle, and the next
// request is accepted once the status transaction of the current one has been loaded into
// the output register. An edit evicts at most QUEUE_DEPTH - 1 entries. Configuration writes
// are always ready and are meant to happen only while no request is in progress.
`include "assert_macros.svh"

module fifo_byte_budget_cache
	import fbc_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	fbc_req_if.sink     req,
	fbc_rsp_if.source   rsp,
	fbc_cfg_if.sink     cfg
);

	state_t state_q, state_d;
	cnt_t   count_q, count_d;
	size_t  bytes_q, bytes_d;
	size_t  others_q, others_d;
	status_t st_q, st_d;
	size_t  budget_q;
	lim_t   limit_q;

	logic [1:0] op_kind_q;
	key_t       op_key_q;
	size_t      op_size_q;

	logic    rsp_vld_q;
	logic    rsp_ev_q;
	key_t    rsp_key_q;
	size_t   rsp_size_q;
	status_t rsp_st_q;
	logic    rsp_last_q;

	entry_t    ent   [QUEUE_DEPTH];
	cell_ctl_t ctl   [QUEUE_DEPTH];
	qvec_t     eq_v, occ_v, load_v, tgt_v, ge_v;
	qvec_t     hit_m, hit_v, oth_m, oth_v;

	logic    drop_en, load_en, upd_en, mark_en, emit, emit_ev, emit_last;
	qvec_t   drop_pos;
	key_t    emit_key;
	size_t   emit_size;
	status_t emit_st;
	logic    can_emit, accept;

	lim_t   lim_eff;
	logic   at_lim, too_big, fits_ins, fits_edit;
	entry_t head, hit_e, oth_e, tgt_e;

	function automatic entry_t pick(input qvec_t oh, input entry_t e [QUEUE_DEPTH]);
		entry_t r;
		r = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (oh[i]) begin
				r = r | e[i];
			end
		end
		return r;
	endfunction

	function automatic size_t sat_sub(input size_t a, input size_t b);
		return (a >= b) ? (a - b) : '0;
	endfunction

	// Row of cells.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t nbr;
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = ent[i+1];
		end

		assign occ_v[i]  = (cnt_t'(i) < count_q);
		assign load_v[i] = (cnt_t'(i) == count_q);
		assign tgt_v[i]  = ent[i].tgt;

		assign ctl[i] = '{shift: drop_en & ge_v[i], load: load_en & load_v[i],
			upd: upd_en, mark: mark_en, mark_val: hit_v[i]};

		fbc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.nbr       (nbr),
			.fill_key  (op_key_q),
			.fill_size (op_size_q),
			.cmp_key   (op_key_q),
			.ent       (ent[i]),
			.eq        (eq_v[i])
		);
	end

	// Oldest matching entry and oldest entry of another key, as one-hot vectors.
	assign hit_m = occ_v & eq_v;
	assign hit_v = hit_m & (~hit_m + qvec_t'(1));
	assign oth_m = occ_v & ~eq_v;
	assign oth_v = oth_m & (~oth_m + qvec_t'(1));
	// Cells at and above the dropped position take their neighbor's contents.
	assign ge_v  = ~(drop_pos - qvec_t'(1));

	assign head  = ent[0];
	assign hit_e = pick(hit_v, ent);
	assign oth_e = pick(oth_v, ent);
	assign tgt_e = pick(tgt_v & occ_v, ent);

	assign lim_eff = (limit_q == '0) ? lim_t'(1) :
		(limit_q > lim_t'(QUEUE_DEPTH)) ? lim_t'(QUEUE_DEPTH) : limit_q;
	assign at_lim    = (lim_t'(count_q) >= lim_eff);
	assign too_big   = (op_size_q > budget_q);
	assign fits_ins  = ({1'b0, bytes_q} + {1'b0, op_size_q}) <= {1'b0, budget_q};
	assign fits_edit = ({1'b0, others_q} + {1'b0, op_size_q}) <= {1'b0, budget_q};

	assign can_emit = !rsp_vld_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		bytes_d   = bytes_q;
		others_d  = others_q;
		st_d      = st_q;
		drop_en   = 1'b0;
		drop_pos  = '0;
		load_en   = 1'b0;
		upd_en    = 1'b0;
		mark_en   = 1'b0;
		emit      = 1'b0;
		emit_ev   = 1'b0;
		emit_key  = '0;
		emit_size = '0;
		emit_st   = ST_OK;
		emit_last = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req.kind)
						KIND_INSERT: state_d = S_INSERT;
						KIND_EDIT:   state_d = S_EDIT_FIND;
						KIND_REMOVE: state_d = S_REMOVE;
						default: begin
							st_d    = ST_OK;
							state_d = S_STATUS;
						end
					endcase
				end
			end
			S_INSERT: begin
				if (too_big) begin
					st_d    = ST_TOO_LARGE;
					state_d = S_STATUS;
				end else if (count_q != '0 && (at_lim || !fits_ins)) begin
					if (can_emit) begin
						emit      = 1'b1;
						emit_ev   = 1'b1;
						emit_key  = head.key;
						emit_size = head.size;
						drop_en   = 1'b1;
						drop_pos  = qvec_t'(1);
						count_d   = count_q - cnt_t'(1);
						bytes_d   = sat_sub(bytes_q, head.size);
					end
				end else begin
					if (count_q < cnt_t'(QUEUE_DEPTH)) begin
						load_en = 1'b1;
						count_d = count_q + cnt_t'(1);
						bytes_d = bytes_q + op_size_q;
					end
					st_d    = ST_OK;
					state_d = S_STATUS;
				end
			end
			S_EDIT_FIND: begin
				if (too_big) begin
					st_d    = ST_TOO_LARGE;
					state_d = S_STATUS;
				end else if (hit_m == '0) begin
					st_d    = ST_NOT_FOUND;
					state_d = S_STATUS;
				end else begin
					mark_en = 1'b1;
					state_d = S_EDIT_CALC;
				end
			end
			S_EDIT_CALC: begin
				others_d = sat_sub(bytes_q, tgt_e.size);
				state_d  = S_EDIT_FIT;
			end
			S_EDIT_FIT: begin
				if (fits_edit) begin
					upd_en  = 1'b1;
					bytes_d = others_q + op_size_q;
					st_d    = ST_OK;
					state_d = S_STATUS;
				end else if (oth_m == '0) begin
					st_d    = ST_STILL_OVER;
					state_d = S_STATUS;
				end else if (can_emit) begin
					emit      = 1'b1;
					emit_ev   = 1'b1;
					emit_key  = oth_e.key;
					emit_size = oth_e.size;
					drop_en   = 1'b1;
					drop_pos  = oth_v;
					count_d   = count_q - cnt_t'(1);
					bytes_d   = sat_sub(bytes_q, oth_e.size);
					state_d   = S_EDIT_CALC;
				end
			end
			S_REMOVE: begin
				if (hit_m == '0) begin
					st_d = ST_NOT_FOUND;
				end else begin
					drop_en  = 1'b1;
					drop_pos = hit_v;
					count_d  = count_q - cnt_t'(1);
					bytes_d  = sat_sub(bytes_q, hit_e.size);
					st_d     = ST_OK;
				end
				state_d = S_STATUS;
			end
			S_STATUS: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_st   = st_q;
					emit_last = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			bytes_q   <= '0;
			st_q      <= ST_OK;
			budget_q  <= BUDGET_RESET;
			limit_q   <= LIMIT_RESET;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			bytes_q <= bytes_d;
			st_q    <= st_d;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_BYTE_BUDGET: budget_q <= cfg.data[SIZE_W-1:0];
					REG_ENTRY_LIMIT: limit_q  <= cfg.data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (emit) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		others_q <= others_d;
		if (accept) begin
			op_kind_q <= req.kind;
			op_key_q  <= req.item_key;
			op_size_q <= req.item_size;
		end
		if (emit) begin
			rsp_ev_q   <= emit_ev;
			rsp_key_q  <= emit_key;
			rsp_size_q <= emit_size;
			rsp_st_q   <= emit_st;
			rsp_last_q <= emit_last;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.is_eviction  = rsp_ev_q;
	assign rsp.evicted_key  = rsp_key_q;
	assign rsp.evicted_size = rsp_size_q;
	assign rsp.status       = rsp_st_q;
	assign rsp.last         = rsp_last_q;

	// The latched kind decides nothing after dispatch; a remove never appends.
	`FBC_ASSERT_NOW(a_no_load_on_remove, clk, arst_n, load_en, op_kind_q == KIND_INSERT, "append outside insert")
	`FBC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= cnt_t'(QUEUE_DEPTH), "entry count above queue depth")
	`FBC_ASSERT_NEXT(a_drop_count, clk, arst_n, drop_en, count_q == $past(count_q) - cnt_t'(1), "drop did not lower count")
	`FBC_ASSERT_NEXT(a_last_idle, clk, arst_n, emit && emit_last, state_q == S_IDLE, "status item did not end the request")

endmodule

>>> tb/sv/tb_fifo_byte_budget_cache.sv
module tb_fifo_byte_budget_cache;
	import fbc_pkg::*;

	localparam logic [1:0] KIND_UNKNOWN = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;

	typedef struct {
		logic [1:0] kind;
		key_t       item_key;
		size_t      item_size;
	} cache_request_t;

	typedef struct {
		logic    is_eviction;
		key_t    evicted_key;
		size_t   evicted_size;
		status_t status;
		logic    last;
	} cache_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fbc_req_if req_ch();
	fbc_rsp_if rsp_ch();
	fbc_cfg_if cfg_ch();

	fifo_byte_budget_cache dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the cache contents and its configuration.
	key_t        cache_key[QUEUE_DEPTH];
	size_t       cache_size[QUEUE_DEPTH];
	int          cache_count = 0;
	logic [63:0] cache_bytes = '0;
	size_t       budget_reg = BUDGET_RESET;
	lim_t        limit_reg = LIMIT_RESET;

	cache_request_t pending_requests[$];
	cache_result_t  expected_results[$];
	cache_request_t next_req;

	bit    req_took = 1'b0;
	bit    stall_on = 1'b1;
	int    n_queued = 0;
	int    n_taken = 0;
	int    n_results = 0;
	int    n_evictions = 0;
	int    n_settings = 0;
	int    n_errors = 0;
	int    stall_cycles = 0;
	size_t plan_budget = BUDGET_RESET;
	lim_t  plan_limit = LIMIT_RESET;

	function automatic int clamp_limit(lim_t v);
		if (v < 1)
			return 1;
		if (v > QUEUE_DEPTH)
			return QUEUE_DEPTH;
		return int'(v);
	endfunction

	function automatic void push_result(logic ev, key_t k, size_t s, status_t st, logic lst);
		cache_result_t res;
		res.is_eviction = ev;
		res.evicted_key = k;
		res.evicted_size = s;
		res.status = st;
		res.last = lst;
		expected_results.push_back(res);
	endfunction

	function automatic void evict_at(int pos, bit report);
		int i;
		if (report)
			push_result(1'b1, cache_key[pos], cache_size[pos], ST_OK, 1'b0);
		cache_bytes = (cache_bytes >= 64'(cache_size[pos])) ? cache_bytes - 64'(cache_size[pos]) : '0;
		for (i = pos; i < cache_count - 1; i++) begin
			cache_key[i] = cache_key[i + 1];
			cache_size[i] = cache_size[i + 1];
		end
		cache_count--;
	endfunction

	function automatic int find_entry(key_t k);
		int i;
		for (i = 0; i < cache_count; i++)
			if (cache_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void apply_request(cache_request_t r);
		status_t     st;
		int          lim;
		int          tgt;
		int          victim;
		bit          settled;
		logic [63:0] others;
		logic [63:0] want_size;
		logic [63:0] budget;
		st = ST_OK;
		want_size = 64'(r.item_size);
		budget = 64'(budget_reg);
		case (r.kind)
			KIND_INSERT: begin
				lim = clamp_limit(limit_reg);
				if (want_size > budget) begin
					st = ST_TOO_LARGE;
				end else begin
					while (cache_count > 0 && cache_count >= lim)
						evict_at(0, 1'b1);
					while (cache_count > 0 && cache_bytes + want_size > budget)
						evict_at(0, 1'b1);
					if (cache_count < QUEUE_DEPTH) begin
						cache_key[cache_count] = r.item_key;
						cache_size[cache_count] = r.item_size;
						cache_count++;
						cache_bytes += want_size;
					end
				end
			end
			KIND_EDIT: begin
				tgt = find_entry(r.item_key);
				if (want_size > budget) begin
					st = ST_TOO_LARGE;
				end else if (tgt < 0) begin
					st = ST_NOT_FOUND;
				end else begin
					settled = 1'b0;
					while (!settled) begin
						others = (cache_bytes >= 64'(cache_size[tgt])) ?
							cache_bytes - 64'(cache_size[tgt]) : '0;
						if (others + want_size <= budget) begin
							cache_size[tgt] = r.item_size;
							cache_bytes = others + want_size;
							settled = 1'b1;
						end else begin
							// Entries sharing the edited key are never evicted.
							victim = 0;
							while (victim < cache_count && cache_key[victim] == r.item_key)
								victim++;
							if (victim >= cache_count) begin
								st = ST_STILL_OVER;
								settled = 1'b1;
							end else begin
								evict_at(victim, 1'b1);
								if (victim < tgt)
									tgt--;
							end
						end
					end
				end
			end
			KIND_REMOVE: begin
				tgt = find_entry(r.item_key);
				if (tgt < 0)
					st = ST_NOT_FOUND;
				else
					evict_at(tgt, 1'b0);
			end
			default: begin
			end
		endcase
		push_result(1'b0, '0, '0, st, 1'b1);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			n_errors++;
		end
	endfunction

	function automatic void check_result();
		cache_result_t want;
		if (expected_results.size() == 0) begin
			$error("result transaction with nothing pending: is_eviction %b key %h size %h",
				rsp_ch.is_eviction, rsp_ch.evicted_key, rsp_ch.evicted_size);
			n_errors++;
		end else begin
			want = expected_results.pop_front();
			check_field("is_eviction", 32'(want.is_eviction), 32'(rsp_ch.is_eviction));
			check_field("evicted_key", 32'(want.evicted_key), 32'(rsp_ch.evicted_key));
			check_field("evicted_size", 32'(want.evicted_size), 32'(rsp_ch.evicted_size));
			check_field("status", 32'(want.status), 32'(rsp_ch.status));
			check_field("last", 32'(want.last), 32'(rsp_ch.last));
		end
	endfunction

	// Monitor: configuration, request and result transactions, plus the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			req_took = req_ch.valid && req_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_BYTE_BUDGET)
					budget_reg = cfg_ch.data;
				else if (cfg_ch.index == REG_ENTRY_LIMIT)
					limit_reg = cfg_ch.data[LIM_W-1:0];
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (rsp_ch.is_eviction === 1'b1)
					n_evictions++;
				check_result();
			end
			if (req_took) begin
				apply_request('{req_ch.kind, req_ch.item_key, req_ch.item_size});
				n_taken++;
			end
			if (req_took || (rsp_ch.valid && rsp_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Driver: requests from the pending queue, result back-pressure.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !stall_on || ($urandom_range(0, 99) >= 14);
			if (!req_ch.valid || req_took) begin
				if (pending_requests.size() != 0 && (!stall_on || $urandom_range(0, 99) >= 14)) begin
					next_req = pending_requests.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind <= next_req.kind;
					req_ch.item_key <= next_req.item_key;
					req_ch.item_size <= next_req.item_size;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic queue_request(input logic [1:0] kind, input key_t k, input size_t s);
		pending_requests.push_back('{kind, k, s});
		n_queued++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	task automatic program_cache(input size_t budget, input lim_t limit);
		write_reg(REG_BYTE_BUDGET, budget);
		write_reg(REG_ENTRY_LIMIT, 32'(limit));
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		plan_budget = budget;
		plan_limit = limit;
		n_settings++;
	endtask

	// Waits for every request to be taken and answered, then lets the block settle.
	task automatic drain();
		while (n_taken != n_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic size_t pick_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return '0;
		if (roll < 14)
			return plan_budget;
		if (roll < 20)
			return $urandom();
		if (roll < 25 && plan_budget != '1)
			return plan_budget + 1;
		if (roll < 45)
			return $urandom_range(0, plan_budget / 2);
		return $urandom_range(0, plan_budget / clamp_limit(plan_limit));
	endfunction

	task automatic queue_random_phase(input int n_items);
		key_t       pool[6];
		int         i;
		int         roll;
		logic [1:0] kind;
		key_t       k;
		for (i = 0; i < 6; i++)
			pool[i] = (i < 3) ? key_t'($urandom_range(0, 15)) : key_t'($urandom());
		for (i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				kind = KIND_INSERT;
			else if (roll < 72)
				kind = KIND_EDIT;
			else if (roll < 94)
				kind = KIND_REMOVE;
			else
				kind = KIND_UNKNOWN;
			k = ($urandom_range(0, 9) == 0) ? key_t'($urandom()) : pool[$urandom_range(0, 5)];
			queue_request(kind, k, pick_size());
		end
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_INSERT;
		req_ch.item_key = '0;
		req_ch.item_size = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_BYTE_BUDGET;
		cfg_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: duplicates, misses, oversize, unknown kind, edit still over.
		queue_request(KIND_INSERT, 32'h1, 32'd0);
		queue_request(KIND_INSERT, 32'hFFFF_FFFF, 32'd100);
		queue_request(KIND_INSERT, 32'h0, 32'd200);
		queue_request(KIND_INSERT, 32'h1, 32'd300);
		queue_request(KIND_EDIT, 32'h1, BUDGET_RESET + 1);
		queue_request(KIND_EDIT, 32'h55, 32'd10);
		queue_request(KIND_REMOVE, 32'h66, 32'd0);
		queue_request(KIND_UNKNOWN, 32'hAAAA_AAAA, 32'h5555_5555);
		queue_request(KIND_EDIT, 32'h1, BUDGET_RESET);
		queue_request(KIND_REMOVE, 32'h1, 32'hFFFF_FFFF);
		queue_request(KIND_EDIT, 32'h1, BUDGET_RESET);
		queue_request(KIND_INSERT, 32'h2, BUDGET_RESET);
		queue_request(KIND_INSERT, 32'h3, 32'hFFFF_FFFF);
		drain();

		program_cache(BUDGET_RESET, lim_t'(4));
		for (p = 0; p < 4; p++)
			queue_request(KIND_INSERT, 32'h100 + p, 32'd1000);
		drain();

		// A limit of zero acts as one, so the whole queue goes at once.
		program_cache(BUDGET_RESET, lim_t'(0));
		queue_request(KIND_INSERT, 32'h200, 32'd7);
		drain();

		// Budget lowered below what is held.
		program_cache(6, lim_t'(40));
		queue_request(KIND_INSERT, 32'h300, 32'd2);
		queue_request(KIND_INSERT, 32'h301, 32'd4);
		queue_request(KIND_EDIT, 32'h300, 32'd6);
		drain();

		program_cache('1, lim_t'(32));
		queue_request(KIND_INSERT, 32'h400, 32'h7FFF_FFFF);
		queue_request(KIND_INSERT, 32'h401, 32'h7FFF_FFFF);
		queue_request(KIND_INSERT, 32'h402, 32'd1);
		queue_request(KIND_INSERT, 32'h403, 32'hFFFF_FFFF);
		drain();

		program_cache(1, lim_t'(1));
		queue_request(KIND_INSERT, 32'h500, 32'd0);
		queue_request(KIND_INSERT, 32'h501, 32'd1);
		queue_request(KIND_INSERT, 32'h502, 32'd2);
		drain();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: program_cache($urandom_range(200, 5000), lim_t'($urandom_range(2, 8)));
				1: begin
					program_cache('1, lim_t'(32));
					stall_on = 1'b0;
				end
				2: begin
					program_cache(BUDGET_RESET, lim_t'(1));
					stall_on = 1'b1;
				end
				3: program_cache($urandom_range(1, 32'hFFFF_FFFF), lim_t'($urandom_range(0, 63)));
				4: program_cache($urandom_range(1, 64), lim_t'($urandom_range(9, 32)));
				default: program_cache($urandom_range(1, 32'hFFFF_FFFF), lim_t'(32));
			endcase
			queue_random_phase(p == 1 ? 48 : 30);
			drain();
		end

		$display("Sent %0d requests under %0d register settings after reset defaults.",
			n_taken, n_settings);
		$display("Checked %0d result transactions, %0d of them evictions; %0d mismatches.",
			n_results, n_evictions, n_errors);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> fifo_byte_budget_cache.f
+incdir+hw/rtl
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_ifs.sv
hw/rtl/fbc_cell.sv
hw/rtl/fifo_byte_budget_cache.sv
tb/sv/tb_fifo_byte_budget_cache.sv
